>>> design/pkl_pkg.sv
package pkl_pkg;

  // Address map
  localparam logic [31:0] PinmuxBaseAddr = 32'd29442336;
  localparam logic [31:0] KickBaseAddr   = 32'd29442104;
  localparam int unsigned PinmuxCount    = 20;
  localparam int unsigned PinmuxIdxW     = (PinmuxCount > 1) ? $clog2(PinmuxCount) : 1;
  localparam logic [31:0] PinmuxSpan     = 32'(4 * (PinmuxCount - 1));
  localparam logic [PinmuxIdxW-1:0] PinmuxLastIdx = PinmuxIdxW'(PinmuxCount - 1);

  // Kick keys and the reserved field of the last pin-mux register
  localparam logic [31:0] KeyFirst         = 32'h83e70b13;
  localparam logic [31:0] KeySecond        = 32'h95a4f1e0;
  localparam logic [31:0] LastReservedMask = 32'hfffffff0;

  // Access kinds and the only legal write size
  localparam logic       FuncRead  = 1'b0;
  localparam logic       FuncWrite = 1'b1;
  localparam logic [3:0] WriteSize = 4'd4;

endpackage

>>> design/pkl_if.sv
interface pkl_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [3:0]  access_size;
  logic        commit;

  modport source (
    output valid, func, address, write_data, access_size, commit,
    input  ready
  );
  modport sink (
    input  valid, func, address, write_data, access_size, commit,
    output ready
  );
endinterface

interface pkl_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] read_data;

  modport source (
    output valid, accepted, read_data,
    input  ready
  );
  modport sink (
    input  valid, accepted, read_data,
    output ready
  );
endinterface

>>> design/pinmux_kick_lock_registers_core.sv
// Pin-mux and kick-lock register block.
// req_i carries one bus access per item: func (read or write), byte address,
// write data, access size and commit. rsp_o returns one item per access:
// accepted, and the stored word for an accepted read (zero otherwise).
// The twenty pin-mux words live in a synchronous memory with a registered
// read; the two kick words and the unlock flag live in flip-flops.
// An accepted item passes through the read stage (memory read data and the
// per-item result parts) and then through the output register.
// The input is taken only while no item is in the read stage, so the block
// cannot take a new item until the previous one has left the read stage.
// A new item is taken while the previous response still waits in the output
// register; when the receiver stalls, the block holds the response and, once
// the next item has been read, stops taking further items until it drains.
// Reset clears the pin-mux valid bits (an unwritten entry reads as zero),
// both kick words and the unlock flag, so the block comes up locked and
// needs no clearing pass.
module pinmux_kick_lock_registers_core
  import pkl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pkl_req_if.sink    req_i,
  pkl_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Pin-mux storage: memory plus a valid bit per entry
  logic [31:0]            mem_q [PinmuxCount];
  logic [PinmuxCount-1:0] vld_q;
  logic [31:0]            mem_rd_q;
  logic                   vld_rd_q;

  logic [31:0] kick_q [2];
  logic        unlocked_q;

  // Per-item result parts held across the read cycle
  logic        ok_q;
  logic        pm_rd_q;
  logic [31:0] kick_rd_q;

  // Output register
  logic        out_vld_q;
  logic        out_ok_q;
  logic [31:0] out_data_q;

  logic                  acc;
  logic [31:0]           off;
  logic                  is_pm;
  logic [PinmuxIdxW-1:0] pm_idx;
  logic                  is_k0;
  logic                  is_k1;
  logic                  is_wr;
  logic                  rsvd_bad;
  logic                  pm_wr;
  logic                  kick_wr;
  logic                  ok;
  logic                  load_out;

  assign acc = req_i.valid && req_i.ready;

  // Decode: pin-mux window first, then the two kick words
  assign off      = req_i.address - PinmuxBaseAddr;
  assign is_pm    = (req_i.address >= PinmuxBaseAddr) && (off <= PinmuxSpan) &&
                    (req_i.address[1:0] == 2'b00);
  assign pm_idx   = off[PinmuxIdxW+1:2];
  assign is_k0    = !is_pm && (req_i.address == KickBaseAddr);
  assign is_k1    = !is_pm && (req_i.address == KickBaseAddr + 32'd4);
  assign is_wr    = (req_i.func == FuncWrite) && (req_i.access_size == WriteSize);
  assign rsvd_bad = (pm_idx == PinmuxLastIdx) &&
                    ((req_i.write_data & LastReservedMask) != 32'd0);
  assign pm_wr    = acc && is_wr && is_pm && !rsvd_bad && req_i.commit && unlocked_q;
  assign kick_wr  = acc && is_wr && (is_k0 || is_k1) && req_i.commit;

  always_comb begin
    ok = 1'b0;
    if (req_i.func == FuncRead) begin
      ok = is_pm || is_k0 || is_k1;
    end else if (req_i.access_size == WriteSize) begin
      ok = (is_pm && !rsvd_bad) || is_k0 || is_k1;
    end
  end

  // Load the output register once the read data is in and the slot is free
  assign load_out = (state_q == S_LOOK) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc)      state_d = S_LOOK;
      S_LOOK: if (load_out) state_d = S_IDLE;
      default:              state_d = S_IDLE;
    endcase
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.accepted  = out_ok_q;
  assign rsp_o.read_data = out_data_q;

  // Memory: write and registered read at the accept edge
  always_ff @(posedge clk_i) begin
    if (pm_wr) begin
      mem_q[pm_idx] <= req_i.write_data;
    end
    if (acc) begin
      mem_rd_q <= mem_q[pm_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      vld_q      <= '0;
      vld_rd_q   <= 1'b0;
      kick_q[0]  <= '0;
      kick_q[1]  <= '0;
      unlocked_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        vld_rd_q <= vld_q[pm_idx];
      end
      if (pm_wr) begin
        vld_q[pm_idx] <= 1'b1;
      end
      // Kick writes: a wrong key relocks, the second key unlocks after the first
      if (kick_wr) begin
        if (is_k0) begin
          kick_q[0] <= req_i.write_data;
          if (req_i.write_data != KeyFirst) unlocked_q <= 1'b0;
        end else begin
          kick_q[1] <= req_i.write_data;
          if (req_i.write_data != KeySecond) begin
            unlocked_q <= 1'b0;
          end else if (kick_q[0] == KeyFirst) begin
            unlocked_q <= 1'b1;
          end
        end
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the per-item result parts until the output register takes them
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ok_q      <= ok;
      pm_rd_q   <= (req_i.func == FuncRead) && is_pm;
      if (req_i.func == FuncRead && is_k0) begin
        kick_rd_q <= kick_q[0];
      end else if (req_i.func == FuncRead && is_k1) begin
        kick_rd_q <= kick_q[1];
      end else begin
        kick_rd_q <= '0;
      end
    end
    if (load_out) begin
      out_ok_q   <= ok_q;
      out_data_q <= pm_rd_q ? (vld_rd_q ? mem_rd_q : 32'd0) : kick_rd_q;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == S_LOOK))
    else $error("accepted item did not enter the read stage");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.accepted) |-> (rsp_o.read_data == 32'd0))
    else $error("refused item carries nonzero read data");

  a_unlock_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(unlocked_q) |-> $past(kick_wr && is_k1 && (req_i.write_data == KeySecond)))
    else $error("unlock without a correct second kick write");

  a_pm_write_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pm_wr |-> unlocked_q)
    else $error("pin-mux write while locked");

  a_no_load_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> !($rose(out_vld_q) && $past(!acc) && (state_q == S_IDLE)))
    else $error("response loaded without an item in the read stage");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pkl_pkg::*;

  // One bus access as offered on the request channel
  typedef struct packed {
    logic        func;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [3:0]  access_size;
    logic        commit;
  } bus_access_t;

  // One reply as returned on the response channel
  typedef struct packed {
    logic        accepted;
    logic [31:0] read_data;
  } bus_reply_t;

  localparam int unsigned RandomAccesses = 1200;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned HoldOffCycles  = 120;
  localparam int unsigned DrainCycles    = 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  pkl_req_if req_if ();
  pkl_rsp_if rsp_if ();

  pinmux_kick_lock_registers_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 4 ns period: two delays, high then low
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Accesses still to be offered, and replies the block still owes
  bus_access_t access_q[$];
  bus_reply_t  reply_q[$];

  // Shadow copy of the register file: pin-mux words, kick words, lock state
  logic [31:0] mux_words [PinmuxCount];
  logic [31:0] kick_words [2];
  logic        unlocked;

  int n_items     = 0;
  int in_count    = 0;
  int n_replies   = 0;
  int n_err       = 0;
  int n_refused   = 0;
  int n_reads     = 0;
  int n_writes    = 0;
  int n_unlocks   = 0;
  int cycle_count = 0;
  int hold_left;
  logic hold_done;

  // ---------------------------------------------------------------------------
  // Predictor: apply one access to the shadow registers and work out the reply.
  // ---------------------------------------------------------------------------
  function automatic bus_reply_t reg_access_reply(bus_access_t a);
    bus_reply_t  r;
    logic [32:0] mux_top;
    logic        is_mux;
    int unsigned slot;
    int          kick;
    r = '0;
    // Compare the pin-mux window in 33 bits so the top bound cannot wrap
    mux_top = {1'b0, PinmuxBaseAddr} + {1'b0, PinmuxSpan};
    is_mux  = ({1'b0, a.address} >= {1'b0, PinmuxBaseAddr}) &&
              ({1'b0, a.address} <= mux_top) && (a.address[1:0] == 2'b00);
    slot    = (a.address - PinmuxBaseAddr) >> 2;
    kick    = (a.address == KickBaseAddr) ? 0 :
              (a.address == KickBaseAddr + 32'd4) ? 1 : -1;
    if (a.func == FuncRead) begin
      // Reads ignore the access size; pin-mux decode wins over kick decode
      if (is_mux) begin
        r.accepted  = 1'b1;
        r.read_data = mux_words[slot];
      end else if (kick >= 0) begin
        r.accepted  = 1'b1;
        r.read_data = kick_words[kick];
      end
    end else if (a.access_size == WriteSize) begin
      if (is_mux) begin
        // Refuse reserved bits in the last register, even when queued or locked
        if (slot == PinmuxCount - 1 && (a.write_data & LastReservedMask) != '0) begin
          r.accepted = 1'b0;
        end else begin
          if (a.commit && unlocked) mux_words[slot] = a.write_data;
          r.accepted = 1'b1;
        end
      end else if (kick >= 0) begin
        r.accepted = 1'b1;
        if (a.commit) begin
          kick_words[kick] = a.write_data;
          // A wrong key relocks; the second key unlocks only after the first
          if (a.write_data != ((kick == 1) ? KeySecond : KeyFirst)) begin
            unlocked = 1'b0;
          end else if (kick == 1 && kick_words[0] == KeyFirst) begin
            if (!unlocked) n_unlocks++;
            unlocked = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mux_addr(int unsigned idx);
    return PinmuxBaseAddr + 32'(4 * idx);
  endfunction

  task automatic queue_access(logic f, logic [31:0] ad, logic [31:0] d,
                              logic [3:0] sz, logic c);
    bus_access_t x;
    x.func        = f;
    x.address     = ad;
    x.write_data  = d;
    x.access_size = sz;
    x.commit      = c;
    access_q.push_back(x);
  endtask

  // Directed opening: extremes, lock sequence and refusals for reserved bits, write size and address
  task automatic queue_directed();
    // Reads straight after reset, with odd sizes too
    queue_access(FuncRead,  mux_addr(0), '0, WriteSize, 1'b0);
    queue_access(FuncRead,  mux_addr(PinmuxCount - 1), 32'hffffffff, 4'd0, 1'b1);
    queue_access(FuncRead,  KickBaseAddr, '0, 4'd15, 1'b0);
    queue_access(FuncRead,  KickBaseAddr + 32'd4, '0, 4'd1, 1'b0);
    // Locked write: accepted, no change
    queue_access(FuncWrite, mux_addr(0), 32'hffffffff, WriteSize, 1'b1);
    queue_access(FuncRead,  mux_addr(0), '0, WriteSize, 1'b0);
    // Unlock, with a queued second key in between that must not count
    queue_access(FuncWrite, KickBaseAddr, KeyFirst, WriteSize, 1'b1);
    queue_access(FuncWrite, KickBaseAddr + 32'd4, KeySecond, WriteSize, 1'b0);
    queue_access(FuncWrite, KickBaseAddr + 32'd4, KeySecond, WriteSize, 1'b1);
    // Committed write lands, queued write does not
    queue_access(FuncWrite, mux_addr(0), 32'hffffffff, WriteSize, 1'b1);
    queue_access(FuncWrite, mux_addr(1), 32'haaaa5555, WriteSize, 1'b0);
    queue_access(FuncRead,  mux_addr(0), '0, 4'd8, 1'b0);
    queue_access(FuncRead,  mux_addr(1), '0, WriteSize, 1'b0);
    // Reserved bits of the last register
    queue_access(FuncWrite, mux_addr(PinmuxCount - 1), 32'h00000010, WriteSize, 1'b1);
    queue_access(FuncWrite, mux_addr(PinmuxCount - 1), 32'h0000000f, WriteSize, 1'b1);
    queue_access(FuncWrite, mux_addr(PinmuxCount - 1), 32'h80000000, WriteSize, 1'b0);
    queue_access(FuncRead,  mux_addr(PinmuxCount - 1), '0, WriteSize, 1'b0);
    // Wrong write sizes
    queue_access(FuncWrite, mux_addr(2), 32'h12345678, 4'd8, 1'b1);
    queue_access(FuncWrite, mux_addr(2), 32'h12345678, 4'd0, 1'b1);
    // Unknown addresses: just outside the window, misaligned, the extremes
    queue_access(FuncRead,  PinmuxBaseAddr - 32'd4, '0, WriteSize, 1'b0);
    queue_access(FuncRead,  mux_addr(PinmuxCount), '0, WriteSize, 1'b0);
    queue_access(FuncWrite, PinmuxBaseAddr + 32'd2, 32'h1, WriteSize, 1'b1);
    queue_access(FuncRead,  32'hffffffff, '0, WriteSize, 1'b0);
    queue_access(FuncWrite, 32'h00000000, 32'h5a5a5a5a, WriteSize, 1'b1);
    // Wrong key relocks; the next write must be dropped
    queue_access(FuncWrite, KickBaseAddr, 32'h12345678, WriteSize, 1'b1);
    queue_access(FuncWrite, mux_addr(3), 32'hdeadbeef, WriteSize, 1'b1);
    queue_access(FuncRead,  mux_addr(3), '0, WriteSize, 1'b0);
  endtask

  // Random part: mostly lock sequences and pin-mux traffic, some noise
  task automatic queue_random(int unsigned count);
    int unsigned n;
    int unsigned pick;
    int unsigned idx;
    logic [31:0] ad;
    logic [31:0] d;
    logic [3:0]  sz;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      idx  = $urandom_range(PinmuxCount - 1);
      sz   = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : WriteSize;
      if (pick < 12) begin
        // Full unlock sequence
        queue_access(FuncWrite, KickBaseAddr, KeyFirst, WriteSize, 1'b1);
        queue_access(FuncWrite, KickBaseAddr + 32'd4, KeySecond, WriteSize, 1'b1);
        n += 2;
      end else if (pick < 20) begin
        // Kick write with a key, a swapped key or noise
        case ($urandom_range(3))
          0:       d = KeyFirst;
          1:       d = KeySecond;
          default: d = $urandom;
        endcase
        queue_access(FuncWrite, KickBaseAddr + 32'(4 * $urandom_range(1)), d, sz,
                     1'($urandom_range(4) != 0));
        n++;
      end else if (pick < 55) begin
        d = $urandom;
        if (idx == PinmuxCount - 1 && $urandom_range(9) < 7) d = 32'($urandom_range(15));
        queue_access(FuncWrite, mux_addr(idx), d, sz, 1'($urandom_range(19) < 17));
        n++;
      end else if (pick < 80) begin
        queue_access(FuncRead, mux_addr(idx), $urandom, 4'($urandom_range(15)),
                     1'($urandom_range(1)));
        n++;
      end else if (pick < 86) begin
        queue_access(FuncRead, KickBaseAddr + 32'(4 * $urandom_range(1)), $urandom,
                     4'($urandom_range(15)), 1'($urandom_range(1)));
        n++;
      end else begin
        // Noise: anywhere, or just beside a decoded address
        if ($urandom_range(1) == 0) begin
          ad = $urandom;
        end else begin
          case ($urandom_range(9))
            0:       ad = PinmuxBaseAddr - 32'd4;
            1:       ad = PinmuxBaseAddr - 32'd1;
            2:       ad = mux_addr(idx) + 32'd1;
            3:       ad = mux_addr(idx) + 32'd2;
            4:       ad = mux_addr(idx) + 32'd3;
            5:       ad = mux_addr(PinmuxCount);
            6:       ad = KickBaseAddr + 32'd1;
            7:       ad = KickBaseAddr + 32'd8;
            8:       ad = KickBaseAddr - 32'd4;
            default: ad = KickBaseAddr + 32'd6;
          endcase
        end
        queue_access(1'($urandom_range(1)), ad, $urandom, 4'($urandom_range(15)),
                     1'($urandom_range(1)));
        n++;
      end
    end
  endtask

  // Idling schedule by accepted items: sender light / receiver heavy, then the
  // other way round, then a final third with no idling at all.
  function automatic int sender_idle_pct();
    if (in_count * 3 < n_items) return 22;
    else if (in_count * 3 < 2 * n_items) return 56;
    else return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (in_count * 3 < n_items) return 56;
    else if (in_count * 3 < 2 * n_items) return 22;
    else return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offer queued accesses, predict each one as it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_access
    bus_access_t cur;
    bus_access_t nxt;
    bus_reply_t  rep;
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.func        <= FuncRead;
      req_if.address     <= '0;
      req_if.write_data  <= '0;
      req_if.access_size <= '0;
      req_if.commit      <= 1'b0;
      in_count           <= 0;
    end else begin
      // Item taken at this edge: update the shadow and record the reply owed
      if (req_if.valid && req_if.ready) begin
        cur.func        = req_if.func;
        cur.address     = req_if.address;
        cur.write_data  = req_if.write_data;
        cur.access_size = req_if.access_size;
        cur.commit      = req_if.commit;
        rep = reg_access_reply(cur);
        reply_q.push_back(rep);
        if (!rep.accepted) n_refused++;
        if (cur.func == FuncWrite) n_writes++;
        else n_reads++;
        in_count <= in_count + 1;
      end
      // Hold an offered item until it is taken; otherwise offer the next or idle
      if (!req_if.valid || req_if.ready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          nxt = access_q.pop_front();
          req_if.func        <= nxt.func;
          req_if.address     <= nxt.address;
          req_if.write_data  <= nxt.write_data;
          req_if.access_size <= nxt.access_size;
          req_if.commit      <= nxt.commit;
          req_if.valid       <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Back-pressure: once, late in the run, hold the receiver off for a long
  // stretch while the sender keeps offering, so the block fills and stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count * 6 >= n_items * 5) begin
      hold_left <= HoldOffCycles;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor: compare each reply with the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_reply
    bus_reply_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_replies++;
        if (reply_q.size() == 0) begin
          $error("reply with no access outstanding: accepted %0d read_data 0x%08h",
                 rsp_if.accepted, rsp_if.read_data);
          n_err++;
        end else begin
          want = reply_q.pop_front();
          if (rsp_if.accepted !== want.accepted) begin
            $error("accepted mismatch: expected %0d, actual %0d",
                   want.accepted, rsp_if.accepted);
            n_err++;
          end
          if (rsp_if.read_data !== want.read_data) begin
            $error("read_data mismatch: expected 0x%08h, actual 0x%08h",
                   want.read_data, rsp_if.read_data);
            n_err++;
          end
        end
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Guard against a hung block
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $error("timeout after %0d cycles: %0d of %0d items taken, %0d replies owed",
             cycle_count, in_count, n_items, reply_q.size());
      $display("** pinmux_kick_lock_registers_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, fill the access queue, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    // Block comes up locked with every register clear
    for (int i = 0; i < PinmuxCount; i++) mux_words[i] = '0;
    kick_words[0] = '0;
    kick_words[1] = '0;
    unlocked      = 1'b0;

    queue_directed();
    queue_random(RandomAccesses);
    n_items = access_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to be taken and every reply to arrive
    while (in_count != n_items || reply_q.size() != 0) @(posedge clk_i);
    // Let any stray reply surface before closing
    repeat (DrainCycles) @(posedge clk_i);
    if (reply_q.size() != 0) begin
      $error("%0d replies never arrived", reply_q.size());
      n_err++;
    end

    $display("Run covered %0d accesses (%0d reads, %0d writes), %0d refused, %0d replies checked.",
             n_items, n_reads, n_writes, n_refused, n_replies);
    $display("Lock opened %0d times; one %0d-cycle receiver hold-off; %0d cycles in total.",
             n_unlocks, HoldOffCycles, cycle_count);
    if (n_err == 0) begin
      $display("** pinmux_kick_lock_registers_core: PASSED **");
    end else begin
      $display("** pinmux_kick_lock_registers_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pkl_pkg.sv
design/pkl_if.sv
design/pinmux_kick_lock_registers_core.sv
tb/sv/tb_top.sv
